FILE: design/slx_pkg.sv
// Shared types, codes and lookup functions for the script lexer.
// Used by slx_dp, slx_ctrl and script_lexer_unit; no dependencies.
package slx_pkg;

  // Defaults for the top-level parameters
  localparam int MaxNameLen = 32;
  localparam int LineBits   = 24;

  // Result kinds
  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_INT    = 6'd1;
  localparam logic [5:0] K_STR    = 6'd5;
  localparam logic [5:0] K_IDENT  = 6'd6;
  localparam logic [5:0] K_CHAR   = 6'd7;
  localparam logic [5:0] K_LPAREN = 6'd16;
  localparam logic [5:0] K_RPAREN = 6'd17;
  localparam logic [5:0] K_LBRACK = 6'd18;
  localparam logic [5:0] K_RBRACK = 6'd19;
  localparam logic [5:0] K_LBRACE = 6'd20;
  localparam logic [5:0] K_RBRACE = 6'd21;
  localparam logic [5:0] K_ASSIGN = 6'd22;
  localparam logic [5:0] K_COMMA  = 6'd23;
  localparam logic [5:0] K_SEMI   = 6'd24;
  localparam logic [5:0] K_PLUS   = 6'd25;
  localparam logic [5:0] K_MINUS  = 6'd26;
  localparam logic [5:0] K_STAR   = 6'd27;
  localparam logic [5:0] K_SLASH  = 6'd28;
  localparam logic [5:0] K_PCT    = 6'd29;
  localparam logic [5:0] K_NOT    = 6'd30;
  localparam logic [5:0] K_LT     = 6'd31;
  localparam logic [5:0] K_GT     = 6'd32;
  localparam logic [5:0] K_LE     = 6'd33;
  localparam logic [5:0] K_GE     = 6'd34;
  localparam logic [5:0] K_EQ     = 6'd35;
  localparam logic [5:0] K_NE     = 6'd36;
  localparam logic [5:0] K_ERR    = 6'd37;

  // Error codes
  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_AFTER_INT = 3'd1;
  localparam logic [2:0] E_BAD_HEX   = 3'd2;
  localparam logic [2:0] E_UNTERM    = 3'd3;
  localparam logic [2:0] E_BAD_ESC   = 3'd4;
  localparam logic [2:0] E_BAD_START = 3'd5;
  localparam logic [2:0] E_LONG_NAME = 3'd6;
  localparam logic [2:0] E_OVERFLOW  = 3'd7;

  // Payload source select
  localparam logic [2:0] PAY_ZERO = 3'd0;
  localparam logic [2:0] PAY_INT  = 3'd1;
  localparam logic [2:0] PAY_BYTE = 3'd2;
  localparam logic [2:0] PAY_CHAR = 3'd3;
  localparam logic [2:0] PAY_RAM  = 3'd4;
  localparam logic [2:0] PAY_HEX  = 3'd5;

  // Literal and keyword table, text right-aligned
  localparam int NumWords = 11;
  localparam logic [63:0] WORD_TXT [NumWords] = '{
    "true", "false", "null", "global", "function", "if", "else",
    "while", "break", "continue", "return"};
  localparam int WORD_LEN [NumWords] = '{4, 5, 4, 6, 8, 2, 4, 5, 5, 8, 6};
  localparam logic [5:0] WORD_KIND [NumWords] = '{
    6'd2, 6'd3, 6'd4, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15};

  typedef struct packed {
    logic       load_byte;
    logic       take;
    logic       emit;
    logic [5:0] kind;
    logic [2:0] err;
    logic [2:0] pay_sel;
    logic [7:0] ch;
    logic       set_pend;
    logic       acc_digit;
    logic       neg_val;
    logic       prod_load;
    logic       acc_prod;
    logic       name_start;
    logic       name_app;
    logic       quote_set;
    logic       hex_hi;
    logic       idx_clr;
    logic       idx_inc;
    logic       ram_re;
    logic       clear_all;
    logic       finish;
  } slx_cmd_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic [7:0] pend;
    logic       quote_single;
    logic       name_full;
    logic       kw_hit;
    logic [5:0] kw_kind;
    logic       over;
    logic       idx_last;
    logic       hold_v;
    logic       emit_ok;
    logic       out_free;
  } slx_stat_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [63:0] payload;
    logic [2:0]  err;
    logic [23:0] line;
    logic        last;
  } slx_res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_name(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (is_digit(b)) v = b - "0";
    else if ((b >= "a") && (b <= "f")) v = b - "a" + 8'd10;
    else v = b - "A" + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c, input logic with_eq);
    logic [5:0] k;
    case (c)
      "=":     k = with_eq ? K_EQ : K_ASSIGN;
      "!":     k = with_eq ? K_NE : K_NOT;
      "<":     k = with_eq ? K_LE : K_LT;
      ">":     k = with_eq ? K_GE : K_GT;
      "+":     k = K_PLUS;
      default: k = K_MINUS;
    endcase
    return k;
  endfunction

  // Single-character punctuators; K_EOF means not one of them
  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ",":     k = K_COMMA;
      ";":     k = K_SEMI;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "%":     k = K_PCT;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  // Character at position p of table word i (zero past its end)
  function automatic logic [7:0] word_char(input int i, input int p);
    logic [63:0] t;
    t = '0;
    if (p < WORD_LEN[i]) t = WORD_TXT[i] >> (8 * (WORD_LEN[i] - 1 - p));
    return t[7:0];
  endfunction

endpackage

FILE: design/slx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module slx_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/slx_dp.sv
// Lexer datapath: byte register, integer accumulator, name buffer, line count,
// keyword match vector and the two-deep result queue. Uses slx_pkg, slx_ram.
module slx_dp
  import slx_pkg::*;
#(
  parameter int MAX_NAME_LEN = MaxNameLen,
  parameter int LINE_BITS    = LineBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  slx_cmd_t    cmd_i,
  input  logic [7:0]  source_byte_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [5:0]  kind_o,
  output logic signed [63:0] payload_o,
  output logic [2:0]  error_code_o,
  output logic [23:0] line_number_o,
  output logic        last_of_run_o,
  output slx_stat_t   stat_o
);

  localparam int AW = $clog2(MAX_NAME_LEN);
  localparam int LW = $clog2(MAX_NAME_LEN + 1);

  logic [7:0]           b_q, pend_q;
  logic [63:0]          acc_q;
  logic                 neg_q, quote_q;
  logic [67:0]          prod_q;
  logic [3:0]           hi_q;
  logic [LW-1:0]        len_q, idx_q;
  logic [LINE_BITS-1:0] line_q, line_inc;
  logic [NumWords-1:0]  kw_q, kw_d;
  logic [7:0]           ram_rdata;
  slx_res_t             hold_q, out_q, res_new, fin_res;
  logic                 hold_v_q, out_v_q, out_free, emit_ok;
  logic                 hold_v_d, out_v_d;
  logic [63:0]          lim, pay;
  logic                 kw_hit;
  logic [5:0]           kw_kind;

  // Name buffer
  slx_ram #(.Width(8), .Depth(MAX_NAME_LEN)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.name_start | cmd_i.name_app),
    .waddr_i (cmd_i.name_start ? '0 : len_q[AW-1:0]),
    .wdata_i (b_q),
    .re_i    (cmd_i.ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Line count, saturating
  assign line_inc = ((b_q == 8'h0A) && (line_q != '1)) ? line_q + LINE_BITS'(1) : line_q;

  // Keyword match: prefix vector updated per appended character
  always_comb begin
    kw_d    = kw_q;
    kw_hit  = 1'b0;
    kw_kind = K_IDENT;
    for (int i = 0; i < NumWords; i++) begin
      if (cmd_i.name_start) kw_d[i] = (word_char(i, 0) == b_q);
      else if (cmd_i.name_app)
        kw_d[i] = kw_q[i] && (int'(len_q) < WORD_LEN[i]) && (word_char(i, int'(len_q)) == b_q);
      if (kw_q[i] && (WORD_LEN[i] == int'(len_q))) begin
        kw_hit  = 1'b1;
        kw_kind = WORD_KIND[i];
      end
    end
  end

  assign lim = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

  // Result assembly
  always_comb begin
    case (cmd_i.pay_sel)
      PAY_INT:  pay = neg_q ? (64'd0 - acc_q) : acc_q;
      PAY_BYTE: pay = 64'(b_q);
      PAY_CHAR: pay = 64'(cmd_i.ch);
      PAY_RAM:  pay = 64'(ram_rdata);
      PAY_HEX:  pay = 64'({hi_q, hex_val(b_q)});
      default:  pay = '0;
    endcase
    res_new.kind    = cmd_i.kind;
    res_new.payload = pay;
    res_new.err     = cmd_i.err;
    res_new.line    = 24'(32'(cmd_i.take ? line_inc : line_q));
    res_new.last    = 1'b0;
  end

  assign out_free = !out_v_q || out_ready_i;
  assign emit_ok  = !hold_v_q || out_free;

  // Lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      quote_q <= 1'b0;
      hi_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      kw_q    <= '0;
      line_q  <= LINE_BITS'(1);
    end else if (cmd_i.clear_all) begin
      pend_q  <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      quote_q <= 1'b0;
      hi_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      kw_q    <= '0;
      line_q  <= LINE_BITS'(1);
    end else begin
      if (cmd_i.take)     line_q <= line_inc;
      if (cmd_i.set_pend) pend_q <= b_q;
      if (cmd_i.acc_digit) begin
        acc_q <= 64'(b_q - "0");
        neg_q <= cmd_i.neg_val;
      end
      if (cmd_i.acc_prod)  acc_q   <= prod_q[63:0];
      if (cmd_i.quote_set) quote_q <= (b_q == "'");
      if (cmd_i.hex_hi)    hi_q    <= hex_val(b_q);
      if (cmd_i.name_start) len_q <= LW'(1);
      else if (cmd_i.name_app) len_q <= len_q + LW'(1);
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + LW'(1);
      kw_q <= kw_d;
    end
  end

  // Byte and multiply-by-ten registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) b_q <= source_byte_i;
    if (cmd_i.prod_load)
      prod_q <= 68'({acc_q, 3'b000}) + 68'({acc_q, 1'b0}) + 68'(b_q - "0");
  end

  // Result queue: one held result plus the output register
  always_comb begin
    out_v_d  = out_v_q && !out_ready_i;
    hold_v_d = hold_v_q;
    if (cmd_i.emit) begin
      if (hold_v_q) out_v_d = 1'b1;
      hold_v_d = 1'b1;
    end
    if (cmd_i.finish) begin
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
    end
    fin_res      = hold_q;
    fin_res.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (hold_v_q) out_q <= hold_q;
      hold_q <= res_new;
    end else if (cmd_i.finish) begin
      out_q <= fin_res;
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_q.kind;
  assign payload_o     = out_q.payload;
  assign error_code_o  = out_q.err;
  assign line_number_o = out_q.line;
  assign last_of_run_o = out_q.last;

  always_comb begin
    stat_o.byte_val     = b_q;
    stat_o.pend         = pend_q;
    stat_o.quote_single = quote_q;
    stat_o.name_full    = (len_q >= LW'(MAX_NAME_LEN));
    stat_o.kw_hit       = kw_hit;
    stat_o.kw_kind      = kw_kind;
    stat_o.over         = (prod_q > 68'(lim));
    stat_o.idx_last     = ((idx_q + LW'(1)) == len_q);
    stat_o.hold_v       = hold_v_q;
    stat_o.emit_ok      = emit_ok;
    stat_o.out_free     = out_free;
  end

`ifndef SYNTHESIS
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.kind == K_ERR)) |-> (out_q.err != E_NONE))
    else $error("error result without an error code");
  a_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.kind != K_ERR)) |-> (out_q.err == E_NONE))
    else $error("error code on a non-error result");
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> emit_ok)
    else $error("result pushed into a full queue");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (hold_v_q && out_free))
    else $error("last result released without room or data");
`endif

endmodule

FILE: design/slx_ctrl.sv
// Lexer controller: lexing mode and the per-byte sequencer that drives the
// datapath commands. Uses slx_pkg.
module slx_ctrl
  import slx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  slx_stat_t stat_i,
  output slx_cmd_t  cmd_o
);

  // Lexing modes
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_COMMENT  = 4'd1;
  localparam logic [3:0] M_OPWAIT   = 4'd2;
  localparam logic [3:0] M_SIGNWAIT = 4'd3;
  localparam logic [3:0] M_INT      = 4'd4;
  localparam logic [3:0] M_IDENT    = 4'd5;
  localparam logic [3:0] M_STR      = 4'd6;
  localparam logic [3:0] M_STRESC   = 4'd7;
  localparam logic [3:0] M_HEX1     = 4'd8;
  localparam logic [3:0] M_HEX2     = 4'd9;
  localparam logic [3:0] M_ERR      = 4'd10;

  // Sequencer states
  localparam logic [2:0] S_WAIT = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_ICHK = 3'd2;
  localparam logic [2:0] S_SQ2  = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FEM  = 3'd5;
  localparam logic [2:0] S_EOF  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d, done_st;
  logic [3:0] mode_q, mode_d;
  logic [7:0] b;
  slx_cmd_t   cmd;

  assign b          = stat_i.byte_val;
  assign done_st    = (b == 8'd0) ? S_EOF : S_FIN;
  assign in_ready_o = (state_q == S_WAIT);

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    mode_d  = mode_q;
    case (state_q)
      S_WAIT: begin
        if (in_valid_i) begin
          cmd.load_byte = 1'b1;
          state_d       = S_RUN;
        end
      end

      // One pass of the lexer over the current byte
      S_RUN: begin
        case (mode_q)
          M_ERR: state_d = done_st;
          M_COMMENT: begin
            if ((b == 8'd0) || (b == 8'h0A)) mode_d = M_IDLE;
            else state_d = done_st;
          end
          M_OPWAIT: begin
            cmd.emit = 1'b1;
            mode_d   = M_IDLE;
            if (b == "=") begin
              cmd.take = 1'b1;
              cmd.kind = op_kind(stat_i.pend, 1'b1);
              state_d  = done_st;
            end else begin
              cmd.kind = op_kind(stat_i.pend, 1'b0);
            end
          end
          M_SIGNWAIT: begin
            if (is_digit(b)) begin
              cmd.take      = 1'b1;
              cmd.acc_digit = 1'b1;
              cmd.neg_val   = (stat_i.pend == "-");
              mode_d        = M_INT;
              state_d       = done_st;
            end else begin
              cmd.emit = 1'b1;
              cmd.kind = op_kind(stat_i.pend, 1'b0);
              mode_d   = M_IDLE;
            end
          end
          M_INT: begin
            if (is_digit(b)) begin
              cmd.take      = 1'b1;
              cmd.prod_load = 1'b1;
              state_d       = S_ICHK;
            end else if (is_alpha(b) || (b == "_")) begin
              cmd.take = 1'b1;
              cmd.emit = 1'b1;
              cmd.kind = K_ERR;
              cmd.err  = E_AFTER_INT;
              mode_d   = M_ERR;
              state_d  = done_st;
            end else begin
              cmd.emit    = 1'b1;
              cmd.kind    = K_INT;
              cmd.pay_sel = PAY_INT;
              mode_d      = M_IDLE;
            end
          end
          M_IDENT: begin
            if (is_name(b)) begin
              cmd.take = 1'b1;
              state_d  = done_st;
              if (stat_i.name_full) begin
                cmd.emit = 1'b1;
                cmd.kind = K_ERR;
                cmd.err  = E_LONG_NAME;
                mode_d   = M_ERR;
              end else begin
                cmd.name_app = 1'b1;
              end
            end else if (stat_i.kw_hit) begin
              cmd.emit = 1'b1;
              cmd.kind = stat_i.kw_kind;
              mode_d   = M_IDLE;
            end else begin
              cmd.emit    = 1'b1;
              cmd.kind    = K_IDENT;
              cmd.idx_clr = 1'b1;
              state_d     = S_FRD;
            end
          end
          M_STR: begin
            state_d = done_st;
            if (b == 8'd0) begin
              cmd.emit = 1'b1;
              cmd.kind = K_ERR;
              cmd.err  = E_UNTERM;
              mode_d   = M_ERR;
            end else begin
              cmd.take = 1'b1;
              if (b == (stat_i.quote_single ? 8'("'") : 8'("\""))) mode_d = M_IDLE;
              else if (b == "\\") mode_d = M_STRESC;
              else begin
                cmd.emit    = 1'b1;
                cmd.kind    = K_CHAR;
                cmd.pay_sel = PAY_BYTE;
              end
            end
          end
          M_STRESC: begin
            state_d = done_st;
            if (b == 8'd0) begin
              cmd.emit = 1'b1;
              cmd.kind = K_ERR;
              cmd.err  = E_UNTERM;
              mode_d   = M_ERR;
            end else begin
              cmd.take = 1'b1;
              cmd.emit = 1'b1;
              cmd.kind = K_CHAR;
              mode_d   = M_STR;
              if (stat_i.quote_single) begin
                if (b inside {"\\", "'", "\""}) begin
                  cmd.pay_sel = PAY_BYTE;
                end else begin
                  // keep the backslash, then the byte itself
                  cmd.pay_sel = PAY_CHAR;
                  cmd.ch      = "\\";
                  state_d     = S_SQ2;
                end
              end else begin
                case (b)
                  "\\", "'", "\"": cmd.pay_sel = PAY_BYTE;
                  "n": begin cmd.pay_sel = PAY_CHAR; cmd.ch = 8'h0A; end
                  "t": begin cmd.pay_sel = PAY_CHAR; cmd.ch = 8'h09; end
                  "r": begin cmd.pay_sel = PAY_CHAR; cmd.ch = 8'h0D; end
                  "f": begin cmd.pay_sel = PAY_CHAR; cmd.ch = 8'h0C; end
                  "0": begin cmd.pay_sel = PAY_CHAR; cmd.ch = 8'h00; end
                  "x": begin
                    cmd.emit = 1'b0;
                    mode_d   = M_HEX1;
                  end
                  default: begin
                    cmd.kind = K_ERR;
                    cmd.err  = E_BAD_ESC;
                    mode_d   = M_ERR;
                  end
                endcase
              end
            end
          end
          M_HEX1, M_HEX2: begin
            state_d = done_st;
            if (b == 8'd0) begin
              cmd.emit = 1'b1;
              cmd.kind = K_ERR;
              cmd.err  = E_UNTERM;
              mode_d   = M_ERR;
            end else begin
              cmd.take = 1'b1;
              if (!is_hex(b)) begin
                cmd.emit = 1'b1;
                cmd.kind = K_ERR;
                cmd.err  = E_BAD_HEX;
                mode_d   = M_ERR;
              end else if (mode_q == M_HEX1) begin
                cmd.hex_hi = 1'b1;
                mode_d     = M_HEX2;
              end else begin
                cmd.emit    = 1'b1;
                cmd.kind    = K_CHAR;
                cmd.pay_sel = PAY_HEX;
                mode_d      = M_STR;
              end
            end
          end
          default: begin
            // Token start
            mode_d  = M_IDLE;
            state_d = done_st;
            if (b != 8'd0) begin
              cmd.take = 1'b1;
              if (is_space(b)) begin
                mode_d = M_IDLE;
              end else if (b == "#") begin
                mode_d = M_COMMENT;
              end else if (b inside {"=", "!", "<", ">"}) begin
                cmd.set_pend = 1'b1;
                mode_d       = M_OPWAIT;
              end else if (b inside {"+", "-"}) begin
                cmd.set_pend = 1'b1;
                mode_d       = M_SIGNWAIT;
              end else if (punct_kind(b) != K_EOF) begin
                cmd.emit = 1'b1;
                cmd.kind = punct_kind(b);
              end else if (b inside {"'", "\""}) begin
                cmd.quote_set = 1'b1;
                cmd.emit      = 1'b1;
                cmd.kind      = K_STR;
                mode_d        = M_STR;
              end else if (is_digit(b)) begin
                cmd.acc_digit = 1'b1;
                cmd.neg_val   = 1'b0;
                mode_d        = M_INT;
              end else if (is_alpha(b) || (b == "_")) begin
                cmd.name_start = 1'b1;
                mode_d         = M_IDENT;
              end else begin
                cmd.emit = 1'b1;
                cmd.kind = K_ERR;
                cmd.err  = E_BAD_START;
                mode_d   = M_ERR;
              end
            end
          end
        endcase
      end

      // Range check of the new accumulator value
      S_ICHK: begin
        state_d = done_st;
        if (stat_i.over) begin
          cmd.emit = 1'b1;
          cmd.kind = K_ERR;
          cmd.err  = E_OVERFLOW;
          mode_d   = M_ERR;
        end else begin
          cmd.acc_prod = 1'b1;
        end
      end

      S_SQ2: begin
        cmd.emit    = 1'b1;
        cmd.kind    = K_CHAR;
        cmd.pay_sel = PAY_BYTE;
        state_d     = done_st;
      end

      // Identifier flush: read a byte, then emit it
      S_FRD: begin
        cmd.ram_re = 1'b1;
        state_d    = S_FEM;
      end
      S_FEM: begin
        cmd.emit    = 1'b1;
        cmd.kind    = K_CHAR;
        cmd.pay_sel = PAY_RAM;
        if (stat_i.idx_last) begin
          mode_d  = M_IDLE;
          state_d = S_RUN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_FRD;
        end
      end

      S_EOF: begin
        cmd.emit      = 1'b1;
        cmd.kind      = K_EOF;
        cmd.clear_all = 1'b1;
        mode_d        = M_IDLE;
        state_d       = S_FIN;
      end

      // Release the last result of this byte
      S_FIN: begin
        if (!stat_i.hold_v) begin
          state_d = S_WAIT;
        end else if (stat_i.out_free) begin
          cmd.finish = 1'b1;
          state_d    = S_WAIT;
        end
      end

      default: state_d = S_WAIT;
    endcase

    // Hold everything while the result queue is full
    if (cmd.emit && !stat_i.emit_ok) begin
      cmd     = '0;
      state_d = state_q;
      mode_d  = mode_q;
    end
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WAIT;
      mode_q  <= M_IDLE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

FILE: design/script_lexer_unit.sv
// Script lexer top level: controller plus datapath.
// Uses slx_pkg, slx_ctrl, slx_dp (which holds the slx_ram name buffer).

// Streaming tokenizer taking one source byte per transfer (byte 0 ends the
// stream and always yields an eof result) and returning token results, each
// flagged last_of_run on the final result caused by a byte. Bytes are handled
// one at a time by a sequencer: a byte is accepted, passes through the lexer
// and has its last result released before the next ready, with a further
// pass for each pending token it terminates, a range check step per integer
// digit, an extra step when a single-quoted string keeps a backslash ahead
// of the byte, an eof result step for byte 0, and a read step and an emit
// step per character when an identifier is flushed, since each character
// is read from the name buffer RAM with a registered read. A one-result
// hold stage plus the output register let the next byte be taken while the
// last result still waits downstream; results beyond that stall the
// sequencer.
module script_lexer_unit
  import slx_pkg::*;
#(
  parameter int MAX_NAME_LEN = MaxNameLen,
  parameter int LINE_BITS    = LineBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         source_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         kind_o,
  output logic signed [63:0] payload_o,
  output logic [2:0]         error_code_o,
  output logic [23:0]        line_number_o,
  output logic               last_of_run_o
);

  slx_cmd_t  cmd;
  slx_stat_t stat;

  slx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  slx_dp #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .LINE_BITS    (LINE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .source_byte_i (source_byte_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .payload_o     (payload_o),
    .error_code_o  (error_code_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o),
    .stat_o        (stat)
  );

endmodule
